FILE: hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants for modular exponentiation
// Operand widths, reducer sizing, register indexes and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // operand and product widths
  localparam int OPERAND_BITS = 31;
  localparam int PROD_BITS    = 2 * OPERAND_BITS;

  // reducer retires this many product bits per cycle
  localparam int RED_RADIX_BITS = 2;
  localparam int RED_CYCLES     = PROD_BITS / RED_RADIX_BITS;

  // counter widths
  localparam int IDX_BITS  = $clog2(OPERAND_BITS);
  localparam int RCNT_BITS = $clog2(RED_CYCLES);

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 1'b1;

  typedef logic [OPERAND_BITS-1:0] opnd_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture base, set up accumulator and bit index
    logic next_bit;  // step the exponent bit index down
    logic mul_sq;    // product <= acc * acc, reducer cleared
    logic mul_base;  // product <= acc * base, reducer cleared
    logic red_step;  // one reducer step, acc written on the last one
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic exp_zero;  // exponent register is zero
    logic mod_zero;  // modulus register is zero
    logic bit_one;   // exponent bit under the index is set
    logic bit_last;  // index is at bit zero
    logic red_last;  // reducer is on its final step
  } sts_t;

endpackage

FILE: hw/rtl/mexp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_dp: modular exponentiation datapath
// Configuration registers, accumulator, one shared multiplier and a
// radix-4 restoring reducer that computes product mod modulus.
// ----------------------------------------------------------------------------
module mexp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mexp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  mexp_pkg::opnd_t                      cfg_data,
  input  mexp_pkg::opnd_t                      in_base,
  input  mexp_pkg::cmd_t                       cmd,
  output mexp_pkg::sts_t                       sts,
  output mexp_pkg::opnd_t                      acc
);

  mexp_pkg::opnd_t                        exp_r;
  mexp_pkg::opnd_t                        mod_r;
  mexp_pkg::opnd_t                        base_r;
  mexp_pkg::opnd_t                        acc_r;
  mexp_pkg::opnd_t                        rem_r;
  logic [mexp_pkg::PROD_BITS-1:0]         prod_r;
  logic [mexp_pkg::IDX_BITS-1:0]          idx_r;
  logic [mexp_pkg::RCNT_BITS-1:0]         rcnt_r;

  mexp_pkg::opnd_t                        mul_b;
  logic [mexp_pkg::PROD_BITS-1:0]         mul_p;
  mexp_pkg::opnd_t                        red_rem;
  logic [mexp_pkg::PROD_BITS-1:0]         red_prod;
  logic [mexp_pkg::OPERAND_BITS:0]        red_trial;
  logic [mexp_pkg::OPERAND_BITS:0]        mod_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
      mod_r <= mexp_pkg::opnd_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mexp_pkg::REG_EXPONENT: exp_r <= cfg_data;
        mexp_pkg::REG_MODULUS:  mod_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier: acc times acc or acc times base
  assign mul_b = cmd.mul_sq ? acc_r : base_r;
  assign mul_p = mexp_pkg::PROD_BITS'(acc_r) * mexp_pkg::PROD_BITS'(mul_b);

  // reducer: shift product bits into the remainder, subtract when it fits
  assign mod_ext = {1'b0, mod_r};
  always_comb begin
    red_rem   = rem_r;
    red_prod  = prod_r;
    red_trial = '0;
    for (int k = 0; k < mexp_pkg::RED_RADIX_BITS; k++) begin
      red_trial = {red_rem, red_prod[mexp_pkg::PROD_BITS-1]};
      red_prod  = {red_prod[mexp_pkg::PROD_BITS-2:0], 1'b0};
      if (red_trial >= mod_ext) begin
        red_trial = red_trial - mod_ext;
      end
      red_rem = red_trial[mexp_pkg::OPERAND_BITS-1:0];
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      rcnt_r <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= mexp_pkg::IDX_BITS'(mexp_pkg::OPERAND_BITS - 1);
      end else if (cmd.next_bit) begin
        idx_r <= idx_r - 1'b1;
      end
      if (cmd.mul_sq || cmd.mul_base) begin
        rcnt_r <= '0;
      end else if (cmd.red_step) begin
        rcnt_r <= rcnt_r + 1'b1;
      end
    end
  end

  // operand, accumulator and reducer registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_base;
      // zero modulus with a nonzero exponent gives zero, otherwise start at one
      acc_r  <= (sts.mod_zero && !sts.exp_zero) ? '0 : mexp_pkg::opnd_t'(1);
    end else if (cmd.red_step && sts.red_last) begin
      acc_r <= red_rem;
    end
    if (cmd.mul_sq || cmd.mul_base) begin
      prod_r <= mul_p;
      rem_r  <= '0;
    end else if (cmd.red_step) begin
      prod_r <= red_prod;
      rem_r  <= red_rem;
    end
  end

  // status back to the controller
  assign sts.exp_zero = (exp_r == '0);
  assign sts.mod_zero = (mod_r == '0);
  assign sts.bit_one  = exp_r[idx_r];
  assign sts.bit_last = (idx_r == '0);
  assign sts.red_last = (rcnt_r == mexp_pkg::RCNT_BITS'(mexp_pkg::RED_CYCLES - 1));

  assign acc = acc_r;

endmodule

FILE: hw/rtl/mexp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_ctrl: modular exponentiation controller
// Walks the exponent bits from the top set bit down, sequencing square and
// multiply-by-base passes through the shared multiplier and reducer.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_free,
  input  mexp_pkg::sts_t  sts,
  output mexp_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            done
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SKIP   = 7'b0000010,
    ST_SQ_MUL = 7'b0000100,
    ST_SQ_RED = 7'b0001000,
    ST_BM_MUL = 7'b0010000,
    ST_BM_RED = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    done      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (sts.exp_zero || sts.mod_zero) ? ST_FIN : ST_SKIP;
        end
      end
      // skip leading zero bits of the exponent
      ST_SKIP: begin
        if (sts.bit_one) begin
          state_nxt = ST_SQ_MUL;
        end else begin
          cmd.next_bit = 1'b1;
        end
      end
      ST_SQ_MUL: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = ST_SQ_RED;
      end
      ST_SQ_RED: begin
        cmd.red_step = 1'b1;
        if (sts.red_last) begin
          if (sts.bit_one) begin
            state_nxt = ST_BM_MUL;
          end else if (sts.bit_last) begin
            state_nxt = ST_FIN;
          end else begin
            cmd.next_bit = 1'b1;
            state_nxt    = ST_SQ_MUL;
          end
        end
      end
      ST_BM_MUL: begin
        cmd.mul_base = 1'b1;
        state_nxt    = ST_BM_RED;
      end
      ST_BM_RED: begin
        cmd.red_step = 1'b1;
        if (sts.red_last) begin
          if (sts.bit_last) begin
            state_nxt = ST_FIN;
          end else begin
            cmd.next_bit = 1'b1;
            state_nxt    = ST_SQ_MUL;
          end
        end
      end
      // hand the result to the output register once it is free
      ST_FIN: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation: base ^ exponent mod modulus
// Left-to-right square-and-multiply over a configured exponent and modulus.
// ----------------------------------------------------------------------------
// One base is worked on at a time. The controller first steps past the
// leading zero bits of the exponent, then from the top set bit down runs a
// squaring for every bit and a multiply by base for every one bit. Each pass
// goes through the shared 31x31 multiplier and then the reducer, which retires
// two product bits per cycle. A zero exponent returns 1 and a zero modulus
// with a nonzero exponent returns 0. Results wait in an output register, and
// the next base is taken while the previous result is still waiting.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mexp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mexp_pkg::OPERAND_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mexp_pkg::OPERAND_BITS-1:0]  in_base,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mexp_pkg::OPERAND_BITS-1:0]  out_power
);

  mexp_pkg::cmd_t  cmd;
  mexp_pkg::sts_t  sts;
  mexp_pkg::opnd_t acc;
  logic            done;
  logic            out_free;
  logic            out_valid_r;
  mexp_pkg::opnd_t out_power_r;

  assign out_free = !out_valid_r || out_ready;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready),
    .done     (done)
  );

  mexp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_base   (in_base),
    .cmd       (cmd),
    .sts       (sts),
    .acc       (acc)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_power_r <= acc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_power = out_power_r;

  // an accepted beat keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // a result is only handed over when the output register can take it
  a_done_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_free)
    else $error("result overwrote a waiting beat");

  // zero exponent always yields one
  a_zero_exp_one: assert property (@(posedge clk) disable iff (!rst_n)
    done && sts.exp_zero |-> acc == mexp_pkg::opnd_t'(1))
    else $error("zero exponent did not give one");

  // at most one of load, multiply and reducer step per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul_sq, cmd.mul_base, cmd.red_step}))
    else $error("conflicting datapath commands");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for modular_exponentiation
// Drives bases through the valid/ready input, reprograms exponent and modulus
// between drained phases, and checks every power against an in-bench
// square-and-multiply predictor, with random idling on both sides.
// ----------------------------------------------------------------------------

// expected powers in order of accepted bases
class power_board;
  mexp_pkg::opnd_t exp_reg;
  mexp_pkg::opnd_t mod_reg;
  mexp_pkg::opnd_t pending[$];
  int unsigned mismatches;

  function new();
    exp_reg    = '0;
    mod_reg    = mexp_pkg::opnd_t'(1);
    mismatches = 0;
  endfunction

  // mirror of a register write
  function void set_reg(logic [mexp_pkg::CFG_IDX_BITS-1:0] idx, mexp_pkg::opnd_t val);
    if (idx == mexp_pkg::REG_EXPONENT) begin
      exp_reg = val;
    end else if (idx == mexp_pkg::REG_MODULUS) begin
      mod_reg = val;
    end
  endfunction

  // left-to-right square and multiply, 64-bit intermediates
  function mexp_pkg::opnd_t predict_power(mexp_pkg::opnd_t b);
    logic [63:0] acc;
    logic [63:0] n;
    logic [63:0] bb;
    bit          started;
    int          i;
    if (exp_reg == '0) return mexp_pkg::opnd_t'(1);
    if (mod_reg == '0) return '0;
    acc     = 64'd1;
    n       = 64'(mod_reg);
    bb      = 64'(b);
    started = 1'b0;
    for (i = mexp_pkg::OPERAND_BITS - 1; i >= 0; i--) begin
      if (started || exp_reg[i]) begin
        started = 1'b1;
        acc = (acc * acc) % n;
        if (exp_reg[i]) acc = (acc * bb) % n;
      end
    end
    return mexp_pkg::opnd_t'(acc);
  endfunction

  function void note_base(mexp_pkg::opnd_t b);
    pending = {pending, predict_power(b)};
  endfunction

  task report(string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  task check_power(mexp_pkg::opnd_t got);
    mexp_pkg::opnd_t want;
    if (pending.size() == 0) begin
      report($sformatf("power %h with no base pending", got));
    end else begin
      want = pending.pop_front();
      if (got !== want) report($sformatf("power got %h want %h", got, want));
    end
  endtask
endclass

module tb_top;

  localparam mexp_pkg::opnd_t OPND_MAX    = '1;
  localparam int              HOLD_CYCLES = 800;
  localparam int              RAND_ITEMS  = 1850;
  localparam int              DRAIN_TAIL  = 2100;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  cfg_we    = 1'b0;
  logic [mexp_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  mexp_pkg::opnd_t cfg_data  = '0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  mexp_pkg::opnd_t in_base   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  mexp_pkg::opnd_t out_power;

  // idle percentages and long hold-off request for the receiver
  int src_idle   = 0;
  int sink_idle  = 0;
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  power_board board = new();

  modular_exponentiation DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_base   (in_base),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_power (out_power)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_base(in_base);
      if (out_valid && out_ready) board.check_power(out_power);
    end
  end

  // one input beat, with random idle cycles ahead of it
  task automatic send_base(input mexp_pkg::opnd_t b);
    while (src_idle > 0 && $urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait for every pending power
  task automatic close_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // program both registers back to back
  task automatic set_config(input mexp_pkg::opnd_t e, input mexp_pkg::opnd_t m);
    cfg_we    <= 1'b1;
    cfg_index <= mexp_pkg::REG_EXPONENT;
    cfg_data  <= e;
    @(posedge clk);
    cfg_index <= mexp_pkg::REG_MODULUS;
    cfg_data  <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_reg(mexp_pkg::REG_EXPONENT, e);
    board.set_reg(mexp_pkg::REG_MODULUS, m);
  endtask

  // exponent: mostly short, some full width, some zero
  function automatic mexp_pkg::opnd_t pick_exponent();
    int              r;
    int              top;
    mexp_pkg::opnd_t low;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r < 3) begin
      top = mexp_pkg::OPERAND_BITS - 1;
    end else if (r == 3) begin
      top = $urandom_range(mexp_pkg::OPERAND_BITS - 2, 8);
    end else begin
      top = $urandom_range(7);
    end
    low = mexp_pkg::opnd_t'($urandom)
          & ((mexp_pkg::opnd_t'(1) << top) - mexp_pkg::opnd_t'(1));
    return (mexp_pkg::opnd_t'(1) << top) | low;
  endfunction

  function automatic mexp_pkg::opnd_t pick_modulus();
    int              r;
    mexp_pkg::opnd_t m;
    r = $urandom_range(15);
    case (r)
      0: return '0;
      1: return mexp_pkg::opnd_t'(1);
      2: return OPND_MAX;
      3: return mexp_pkg::opnd_t'(2);
      4, 5, 6, 7: return mexp_pkg::opnd_t'($urandom_range(1000, 2));
      default: begin
        m = mexp_pkg::opnd_t'($urandom);
        if (m < 2) m = mexp_pkg::opnd_t'(3);
        return m;
      end
    endcase
  endfunction

  function automatic mexp_pkg::opnd_t pick_base(input mexp_pkg::opnd_t m);
    int r;
    r = $urandom_range(9);
    case (r)
      0: return '0;
      1: return mexp_pkg::opnd_t'(1);
      2: return OPND_MAX;
      3: return (m != '0) ? m - mexp_pkg::opnd_t'(1) : mexp_pkg::opnd_t'($urandom);
      4: return m;
      default: return mexp_pkg::opnd_t'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    int              sent;
    int              n;
    int              k;
    mexp_pkg::opnd_t e;
    mexp_pkg::opnd_t m;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idling as in the first random stretch
    src_idle  = 37;
    sink_idle <= 57;

    // registers straight out of reset: zero exponent, modulus one
    send_base('0);
    send_base(OPND_MAX);
    close_phase();

    // zero exponent with zero modulus still gives one
    set_config('0, '0);
    send_base(mexp_pkg::opnd_t'(7));
    close_phase();

    // zero modulus with a nonzero exponent gives zero
    set_config(mexp_pkg::opnd_t'(1), '0);
    send_base(mexp_pkg::opnd_t'(5));
    close_phase();

    // modulus one gives zero
    set_config(OPND_MAX, mexp_pkg::opnd_t'(1));
    send_base(OPND_MAX);
    close_phase();

    // all-ones exponent and modulus, extreme bases
    set_config(OPND_MAX, OPND_MAX);
    send_base('0);
    send_base(mexp_pkg::opnd_t'(1));
    send_base(mexp_pkg::opnd_t'(2));
    send_base(OPND_MAX);
    send_base(OPND_MAX - mexp_pkg::opnd_t'(1));
    close_phase();

    // exponent one: a single multiply by an unreduced base
    set_config(mexp_pkg::opnd_t'(1), OPND_MAX);
    send_base(OPND_MAX);
    send_base(OPND_MAX - mexp_pkg::opnd_t'(1));
    close_phase();

    // power-of-two modulus, exponent two: square of the base
    set_config(mexp_pkg::opnd_t'(2), mexp_pkg::opnd_t'(31'h4000_0000));
    send_base(OPND_MAX);
    send_base(mexp_pkg::opnd_t'(31'h2AAA_AAAA));
    close_phase();

    // single top exponent bit: long run of squarings
    set_config(mexp_pkg::opnd_t'(31'h4000_0000), mexp_pkg::opnd_t'(1000003));
    send_base(mexp_pkg::opnd_t'(3));
    send_base(OPND_MAX);
    close_phase();

    // smallest useful modulus
    set_config(mexp_pkg::opnd_t'(1), mexp_pkg::opnd_t'(2));
    send_base('0);
    send_base(mexp_pkg::opnd_t'(1));
    close_phase();

    // receiver holds off while bases keep coming
    m = mexp_pkg::opnd_t'($urandom) | mexp_pkg::opnd_t'(31'h4000_0000);
    set_config(mexp_pkg::opnd_t'(3), m);
    hold_token <= hold_token + 1;
    for (k = 0; k < 16; k++) send_base(pick_base(m));
    close_phase();

    // random phases: new registers after each drain
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent < RAND_ITEMS / 3) begin
        src_idle  = 37;
        sink_idle <= 57;
      end else if (sent < 2 * RAND_ITEMS / 3) begin
        src_idle  = 57;
        sink_idle <= 37;
      end else begin
        src_idle  = 0;
        sink_idle <= 0;
      end
      e = pick_exponent();
      m = pick_modulus();
      set_config(e, m);
      n = e[mexp_pkg::OPERAND_BITS-1] ? $urandom_range(16, 8) : $urandom_range(70, 20);
      for (k = 0; k < n; k++) send_base(pick_base(m));
      sent += n;
      close_phase();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #(64'd200_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_dp.sv
hw/rtl/mexp_ctrl.sv
hw/rtl/modular_exponentiation.sv
tb/tb_top.sv
